// ----- hdl/tkm_pkg.sv -----
// shared constants of the timestamp k-way merge
// no dependencies
`default_nettype none
package tkm_pkg;
	localparam int NUM_STREAMS_DEF = 16;
	localparam int INPUT_REACH     = 16;
	localparam int IDX_W           = 4;
	localparam int TS_W            = 64;
	localparam int TAG_W           = 32;
	localparam int CFG_W           = 5;
endpackage
`default_nettype wire

// ----- hdl/tkm_ram.sv -----
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none
module tkm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                     clk,
	input  wire logic                                     we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                         wdata,
	input  wire logic                                     re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

// ----- hdl/timestamp_kway_merge.sv -----
// timestamp k-way merge, top level
// the input that completes the head set starts a scan with one head-memory read per
//   effective stream, each read compared, and the emit state then loads the output
//   register (all_done skips the scan); one input every cycle while no result is due;
//   inputs then wait until the result is in the output register, longer while it stalls
// reset: arst_n asynchronous, active low; clears slot flags, merge state, stream count to 1
`default_nettype none
module timestamp_kway_merge #(
	parameter int NUM_STREAMS = tkm_pkg::NUM_STREAMS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// configuration write channel
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [tkm_pkg::CFG_W-1:0] cfg_data,
	// input events
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [tkm_pkg::IDX_W-1:0] stream_index,
	input  wire logic [tkm_pkg::TS_W-1:0]  timestamp,
	input  wire logic [tkm_pkg::TAG_W-1:0] event_tag,
	input  wire logic                      end_of_stream,
	// merged output
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [tkm_pkg::IDX_W-1:0]      out_stream,
	output logic [tkm_pkg::TS_W-1:0]       out_timestamp,
	output logic [tkm_pkg::TAG_W-1:0]      out_tag,
	output logic                           all_done
);
	import tkm_pkg::*;

	// streams that can ever be addressed
	localparam int LIMIT  = (NUM_STREAMS < INPUT_REACH) ? NUM_STREAMS : INPUT_REACH;
	localparam int CNT_W  = $clog2(LIMIT + 1);
	localparam int SLOT_W = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
	localparam int DATA_W = TS_W + TAG_W;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t                 state_q;
	logic [CFG_W-1:0]       cfg_q;
	logic [NUM_STREAMS-1:0] head_valid_q;
	logic [NUM_STREAMS-1:0] finished_q;
	logic                   merge_done_q;

	// scan loop
	logic [CNT_W-1:0]  n_q;
	logic [CNT_W-1:0]  rd_q;
	logic              rd_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic              any_q;
	logic [SLOT_W-1:0] best_slot_q;
	logic [TS_W-1:0]   best_time_q;
	logic [TAG_W-1:0]  best_tag_q;

	// output register
	logic              out_valid_q;
	logic [IDX_W-1:0]  out_stream_q;
	logic [TS_W-1:0]   out_time_q;
	logic [TAG_W-1:0]  out_tag_q;
	logic              all_done_q;

	logic [CNT_W-1:0]  n_eff;
	logic [SLOT_W-1:0] s_slot;
	logic              in_range;
	logic              take;
	logic              set_ready;
	logic              set_any;
	logic              accept;
	logic              ram_re;
	logic [DATA_W-1:0] ram_rdata;
	logic [TS_W-1:0]   rd_time;
	logic [TAG_W-1:0]  rd_tag;
	logic              out_free;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	// effective stream count: zero acts as one, large values saturate
	always_comb begin
		if (cfg_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (int'(cfg_q) > LIMIT) begin
			n_eff = CNT_W'(LIMIT);
		end else begin
			n_eff = CNT_W'(cfg_q);
		end
	end

	// slot check and readiness of the head set after this transaction
	always_comb begin
		s_slot    = SLOT_W'(stream_index);
		in_range  = int'(stream_index) < int'(n_eff);
		take      = in_range && !merge_done_q && !head_valid_q[s_slot] && !finished_q[s_slot];
		set_ready = 1'b1;
		set_any   = 1'b0;
		for (int i = 0; i < NUM_STREAMS; i++) begin
			if (i < int'(n_eff)) begin
				if (!head_valid_q[i] && !finished_q[i] && !(SLOT_W'(i) == s_slot)) begin
					set_ready = 1'b0;
				end
				if (head_valid_q[i] || (SLOT_W'(i) == s_slot && !end_of_stream)) begin
					set_any = 1'b1;
				end
			end
		end
	end

	assign ram_re = (state_q == ST_SCAN) && (rd_q < n_q);
	assign rd_time = ram_rdata[DATA_W-1:TAG_W];
	assign rd_tag  = ram_rdata[TAG_W-1:0];

	// head timestamps and tags, one entry per stream
	tkm_ram #(
		.WIDTH(DATA_W),
		.DEPTH(NUM_STREAMS)
	) u_head_ram (
		.clk  (clk),
		.we   (accept && take && !end_of_stream),
		.waddr(s_slot),
		.wdata({timestamp, event_tag}),
		.re   (ram_re),
		.raddr(SLOT_W'(rd_q)),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cfg_q        <= CFG_W'(1);
			head_valid_q <= '0;
			finished_q   <= '0;
			merge_done_q <= 1'b0;
			rd_s1        <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				cfg_q <= cfg_data;
			end
			// a new result refills the register in the cycle the old one leaves
			if (state_q == ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			rd_s1 <= ram_re;
			case (state_q)
				ST_IDLE: begin
					if (accept && take) begin
						if (end_of_stream) begin
							finished_q[s_slot] <= 1'b1;
						end else begin
							head_valid_q[s_slot] <= 1'b1;
						end
						if (set_ready) begin
							// no heads left means the final transaction
							state_q <= set_any ? ST_SCAN : ST_EMIT;
						end
					end
				end
				ST_SCAN: begin
					// leave once the last read has been compared
					if (rd_q == n_q && !rd_s1) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						if (any_q) begin
							head_valid_q[best_slot_q] <= 1'b0;
						end else begin
							merge_done_q <= 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// scan datapath, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			n_q   <= n_eff;
			rd_q  <= '0;
			any_q <= 1'b0;
		end
		if (ram_re) begin
			rd_q <= rd_q + CNT_W'(1);
		end
		slot_s1 <= SLOT_W'(rd_q);
		// strict compare keeps the lower stream on a tie
		if (rd_s1 && head_valid_q[slot_s1] && (!any_q || rd_time < best_time_q)) begin
			any_q       <= 1'b1;
			best_slot_q <= slot_s1;
			best_time_q <= rd_time;
			best_tag_q  <= rd_tag;
		end
		if (state_q == ST_EMIT && out_free) begin
			if (any_q) begin
				out_stream_q <= IDX_W'(best_slot_q);
				out_time_q   <= best_time_q;
				out_tag_q    <= best_tag_q;
				all_done_q   <= 1'b0;
			end else begin
				out_stream_q <= '0;
				out_time_q   <= '0;
				out_tag_q    <= '0;
				all_done_q   <= 1'b1;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign out_stream    = out_stream_q;
	assign out_timestamp = out_time_q;
	assign out_tag       = out_tag_q;
	assign all_done      = all_done_q;
endmodule
`default_nettype wire

// ----- verif/timestamp_kway_merge_tb.sv -----
// self-checking testbench for the timestamp k-way merge: directed and random event traffic
// with its own model of the head slots, the stream count and the merge order
// depends on tkm_pkg and timestamp_kway_merge
`timescale 1ns / 100ps
module timestamp_kway_merge_tb;
	import tkm_pkg::*;

	// one merged output transaction as the model predicts it
	typedef struct {
		logic [IDX_W-1:0] stream;
		logic [TS_W-1:0]  stamp;
		logic [TAG_W-1:0] tag;
		logic             done;
	} merged_ev_t;

	localparam int SLOTS     = NUM_STREAMS_DEF;
	localparam int SCAN_WAIT = SLOTS + 8;  // longest scan plus margin

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CFG_W-1:0] cfg_data = '0;

	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [IDX_W-1:0] stream_index = '0;
	logic [TS_W-1:0]  timestamp = '0;
	logic [TAG_W-1:0] event_tag = '0;
	logic             end_of_stream = 1'b0;

	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [IDX_W-1:0] out_stream;
	logic [TS_W-1:0]  out_timestamp;
	logic [TAG_W-1:0] out_tag;
	logic             all_done;

	timestamp_kway_merge dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.stream_index  (stream_index),
		.timestamp     (timestamp),
		.event_tag     (event_tag),
		.end_of_stream (end_of_stream),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_stream    (out_stream),
		.out_timestamp (out_timestamp),
		.out_tag       (out_tag),
		.all_done      (all_done)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// merge model state
	// ---------------------------------------------------------------
	logic [CFG_W-1:0] stream_count_reg;
	logic             head_full [SLOTS];
	logic [TS_W-1:0]  head_stamp [SLOTS];
	logic [TAG_W-1:0] head_tag [SLOTS];
	logic             stream_closed [SLOTS];
	logic             merge_done;

	// merged events still on their way out, oldest first
	merged_ev_t merge_order_q [$];

	int mismatches = 0;
	int events_sent = 0;
	int merged_seen = 0;
	int done_seen = 0;
	int counts_written = 0;
	int burst_left = 0;

	// effective stream count: zero acts as one, large values saturate
	function automatic int live_streams();
		int n;
		n = stream_count_reg;
		if (n < 1)
			n = 1;
		if (n > SLOTS)
			n = SLOTS;
		if (n > INPUT_REACH)
			n = INPUT_REACH;
		return n;
	endfunction

	// apply one accepted input transaction; queue the merged event it releases, if any
	function automatic void merge_accept(input logic [IDX_W-1:0] s, input logic [TS_W-1:0] ts,
		input logic [TAG_W-1:0] tag, input logic eos);
		int n;
		int i;
		int best;
		bit has_head;
		merged_ev_t ev;
		n = live_streams();
		best = 0;
		has_head = 1'b0;
		// ignored: merge over, stream out of range, slot busy or stream finished
		if (merge_done || s >= n || head_full[s] || stream_closed[s])
			return;
		if (eos) begin
			stream_closed[s] = 1'b1;
		end else begin
			head_full[s] = 1'b1;
			head_stamp[s] = ts;
			head_tag[s] = tag;
		end
		// nothing leaves until every live stream has a head or is finished
		for (i = 0; i < n; i++)
			if (!head_full[i] && !stream_closed[i])
				return;
		// earliest head wins, ties go to the lower stream
		for (i = 0; i < n; i++) begin
			if (head_full[i] && (!has_head || head_stamp[i] < head_stamp[best])) begin
				best = i;
				has_head = 1'b1;
			end
		end
		if (has_head) begin
			ev.stream = best[IDX_W-1:0];
			ev.stamp = head_stamp[best];
			ev.tag = head_tag[best];
			ev.done = 1'b0;
			head_full[best] = 1'b0;
		end else begin
			ev.stream = '0;
			ev.stamp = '0;
			ev.tag = '0;
			ev.done = 1'b1;
			merge_done = 1'b1;
		end
		merge_order_q.insert(merge_order_q.size(), ev);
	endfunction

	// a live stream whose slot can take an event, or -1 if there is none
	function automatic int pick_open_stream();
		int open_list [$];
		int i;
		for (i = 0; i < live_streams(); i++)
			if (!head_full[i] && !stream_closed[i])
				open_list.insert(open_list.size(), i);
		if (open_list.size() == 0)
			return -1;
		return open_list[$urandom_range(0, open_list.size() - 1)];
	endfunction

	// timestamp mix: extremes, a narrow band that makes ties, and full-width values
	function automatic logic [TS_W-1:0] rand_stamp();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3, 4: return TS_W'($urandom_range(0, 15));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// ---------------------------------------------------------------
	// receiver: random stall pattern that changes mode from run to run of its counter
	// ---------------------------------------------------------------
	logic [1:0] stall_mode = 2'd0;
	int         stall_left = 0;
	logic [1:0] stall_phase = 2'd0;

	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= 2'($urandom_range(0, 3));
			stall_left <= $urandom_range(16, 96);
		end else begin
			stall_left <= stall_left - 1;
		end
		stall_phase <= stall_phase + 2'd1;
		case (stall_mode)
			2'd0: out_ready <= 1'b1;                          // no stalls at all
			2'd1: out_ready <= 1'($urandom_range(0, 1));      // coin flip
			2'd2: out_ready <= (stall_phase != 2'd0);         // one stall in four
			default: out_ready <= ($urandom_range(0, 4) == 0); // mostly stalled
		endcase
	end

	// ---------------------------------------------------------------
	// checker: every output transaction against the oldest predicted event
	// ---------------------------------------------------------------
	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= 100)
			$display("%0t mismatch: %s", $realtime, what);
	endtask

	always @(posedge clk) begin
		merged_ev_t want;
		if (arst_n && out_valid && out_ready) begin
			if (merge_order_q.size() == 0) begin
				report_mismatch($sformatf("unexpected output, stream %0d ts %0h",
					out_stream, out_timestamp));
			end else begin
				want = merge_order_q.pop_front();
				if (out_stream !== want.stream)
					report_mismatch($sformatf("out_stream %0d, want %0d",
						out_stream, want.stream));
				if (out_timestamp !== want.stamp)
					report_mismatch($sformatf("out_timestamp %0h, want %0h",
						out_timestamp, want.stamp));
				if (out_tag !== want.tag)
					report_mismatch($sformatf("out_tag %0h, want %0h", out_tag, want.tag));
				if (all_done !== want.done)
					report_mismatch($sformatf("all_done %0b, want %0b", all_done, want.done));
				if (want.done)
					done_seen++;
				else
					merged_seen++;
			end
		end
	end

	// ---------------------------------------------------------------
	// sender side, always entered right after a rising edge
	// ---------------------------------------------------------------

	// one input transaction; bursts of random length with random gaps in between
	task automatic push_event(input int s, input logic [TS_W-1:0] ts,
		input logic [TAG_W-1:0] tag, input logic eos);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		stream_index <= s[IDX_W-1:0];
		timestamp <= ts;
		event_tag <= tag;
		end_of_stream <= eos;
		do @(posedge clk); while (!in_ready);
		events_sent++;
		merge_accept(s[IDX_W-1:0], ts, tag, eos);
	endtask

	// drop valid, let the predicted events drain, then let any scan in flight finish
	task automatic quiesce();
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		while (merge_order_q.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (SCAN_WAIT) @(posedge clk);
	endtask

	// stream count register write, only while the block is idle
	task automatic set_stream_count(input logic [CFG_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		stream_count_reg = v;
		counts_written++;
	endtask

	// feed late events until stream 0 is free, so any new count leaves a slot to fill;
	// max timestamps push every other head out first, then ties release stream 0
	task automatic settle_stream_zero();
		int s;
		while (head_full[0] && !merge_done) begin
			s = pick_open_stream();
			if (s < 0)
				break;
			push_event(s, '1, $urandom, 1'b0);
		end
	endtask

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// single stream after reset, field extremes, out-of-range streams, count zero
	task automatic test_single_stream();
		push_event(0, '0, '0, 1'b0);
		push_event(0, '1, '1, 1'b0);
		push_event(1, 64'd5, 32'd5, 1'b0);
		push_event(15, '1, '1, 1'b1);
		quiesce();
		set_stream_count(5'd0);
		push_event(0, 64'h5555_5555_5555_5555, 32'hAAAA_AAAA, 1'b0);
		push_event(1, 64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555, 1'b0);
	endtask

	// busy slot, and a count change that leaves the slots complete but silent
	task automatic test_count_change();
		quiesce();
		set_stream_count(5'd2);
		push_event(0, 64'd5, 32'h0000_0500, 1'b0);
		push_event(0, 64'd9, 32'h0000_0900, 1'b0);
		push_event(1, 64'd3, 32'h0000_0300, 1'b0);
		quiesce();
		set_stream_count(5'd1);
		push_event(0, 64'd11, 32'h0000_1100, 1'b0);
		push_event(1, 64'd12, 32'h0000_1200, 1'b0);
		quiesce();
		set_stream_count(5'd2);
		push_event(1, 64'd7, 32'h0000_0700, 1'b0);
	endtask

	// equal timestamps, end of stream releasing a tie, input to a finished stream
	task automatic test_ties_and_finish();
		quiesce();
		set_stream_count(5'd4);
		push_event(3, 64'd100, 32'h0300_0100, 1'b0);
		push_event(2, 64'd100, 32'h0200_0100, 1'b0);
		push_event(0, 64'd100, 32'h0000_0100, 1'b0);
		push_event(1, rand_stamp(), $urandom, 1'b1);
		push_event(1, 64'd1, 32'h0100_0001, 1'b0);
		push_event(0, 64'd100, 32'h0000_0101, 1'b0);
	endtask

	// random traffic over a sweep of stream counts, extremes included;
	// mostly events for open slots, the rest arbitrary noise
	task automatic test_random_phases();
		logic [CFG_W-1:0] sweep [8] = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd5, 5'd11, 5'd2, 5'd16};
		int s;
		foreach (sweep[p]) begin
			settle_stream_zero();
			quiesce();
			set_stream_count(sweep[p]);
			repeat (150) begin
				s = pick_open_stream();
				if (s >= 0 && $urandom_range(0, 9) < 8) begin
					push_event(s, rand_stamp(), $urandom, 1'b0);
				end else begin
					// stream 0 is never closed here so the merge keeps running
					s = $urandom_range(0, 15);
					push_event(s, rand_stamp(), $urandom,
						(s != 0) && ($urandom_range(0, 6) == 0));
				end
			end
		end
	endtask

	// close every stream until the final all_done, then show later inputs are dropped
	task automatic test_drain();
		int s;
		settle_stream_zero();
		quiesce();
		set_stream_count(5'd16);
		while (!merge_done) begin
			s = pick_open_stream();
			if (s < 0)
				break;
			push_event(s, rand_stamp(), $urandom, 1'b1);
		end
		push_event(0, 64'd1, 32'h1, 1'b0);
		push_event(3, '1, '1, 1'b1);
		push_event(15, '0, '0, 1'b0);
	endtask

	// ---------------------------------------------------------------
	// main sequence
	// ---------------------------------------------------------------
	initial begin
		int i;
		stream_count_reg = 5'd1;
		merge_done = 1'b0;
		for (i = 0; i < SLOTS; i++) begin
			head_full[i] = 1'b0;
			head_stamp[i] = '0;
			head_tag[i] = '0;
			stream_closed[i] = 1'b0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_single_stream();
		test_count_change();
		test_ties_and_finish();
		test_random_phases();
		test_drain();
		quiesce();

		if (merge_order_q.size() != 0)
			report_mismatch($sformatf("%0d merged events never came out",
				merge_order_q.size()));

		$display("covered %0d input transactions and %0d stream-count writes",
			events_sent, counts_written);
		$display("checked %0d merged events and %0d end-of-merge marks",
			merged_seen, done_seen);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// hang guard, far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("timeout waiting on the merge");
		$display("FAILED: results differ");
		$finish;
	end

endmodule
